### hdl/casu_pkg.sv
// casu_pkg: types, codes and helper functions of the command line argument splitter
// no dependencies; imported by every other file of the block but casu_if
package casu_pkg;

  localparam int unsigned MaxArgsDefault = 255;

  localparam logic [15:0] CuBslash = 16'h005C;
  localparam logic [15:0] CuDquote = 16'h0022;
  localparam logic [15:0] CuSquote = 16'h0027;

  typedef enum logic [1:0] {
    KIND_CHAR = 2'd0,
    KIND_END  = 2'd1,
    KIND_OK   = 2'd2,
    KIND_ERR  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_NO_SPACE   = 3'd1,
    ERR_UNMATCHED  = 3'd2,
    ERR_QUOTE_IN   = 3'd3,
    ERR_NO_PROGRAM = 3'd4
  } err_code_t;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_PLAIN  = 2'd1,
    PH_QUOTED = 2'd2,
    PH_CLOSED = 2'd3
  } phase_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] char_out;
    logic [7:0]  arg_number;
    err_code_t   error_code;
    logic        last_of_run;
  } result_t;

  // all results caused by one item
  typedef struct packed {
    logic [1:0]        n;
    result_t [2:0]     res;
  } bundle_t;

  function automatic logic is_space(input logic [15:0] c);
    logic sp;
    sp = (c == 16'h0020) || (c >= 16'h0009 && c <= 16'h000D) ||
         (c == 16'h0085) || (c == 16'h00A0) || (c == 16'h1680) ||
         (c >= 16'h2000 && c <= 16'h200A) ||
         (c == 16'h2028) || (c == 16'h2029) || (c == 16'h202F) ||
         (c == 16'h205F) || (c == 16'h3000);
    return sp;
  endfunction

  function automatic result_t mk_result(input kind_t k, input logic [15:0] ch,
                                        input logic [7:0] cnt, input err_code_t e);
    result_t r;
    r.kind        = k;
    r.char_out    = ch;
    r.arg_number  = cnt;
    r.error_code  = e;
    r.last_of_run = 1'b0;
    return r;
  endfunction

endpackage

### hdl/casu_if.sv
// casu_if: valid/ready channel interfaces for the input and result items
// depends on nothing; used by the top level and its submodules
interface casu_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        end_of_command;

  modport source (output valid, output code_unit, output end_of_command, input ready);
  modport sink   (input valid, input code_unit, input end_of_command, output ready);
endinterface

interface casu_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] char_out;
  logic [7:0]  arg_number;
  logic [2:0]  error_code;
  logic        last_of_run;

  modport source (output valid, output kind, output char_out, output arg_number,
                  output error_code, output last_of_run, input ready);
  modport sink   (input valid, input kind, input char_out, input arg_number,
                  input error_code, input last_of_run, output ready);
endinterface

### hdl/command_line_argument_splitter_unit.sv
// command_line_argument_splitter_unit: top level, splits a command line into arguments
// depends on casu_pkg, casu_if, casu_parse and casu_emit
//
//   channel  direction  payload                                              handshake
//   in_ch    in         code_unit[16], end_of_command                         valid/ready
//   out_ch   out        kind[2], char_out[16], arg_number[8], error_code[3],  valid/ready
//                       last_of_run
//
// an item holds the parser until the result buffer has handed its last result to
// the output register, one result per cycle while the output is not stalled; items
// with no result do not hold it
// a result passes from the input register via the result buffer to the output register
// synchronous active-low reset returns the parser to between arguments, count zero
// a stalled output fills the result buffer, then the input register, then drops in_ch.ready
module command_line_argument_splitter_unit #(
  parameter int unsigned MAX_ARGS = casu_pkg::MaxArgsDefault
) (
  input logic         clk,
  input logic         rst_n,
  casu_in_if.sink     in_ch,
  casu_out_if.source  out_ch
);
  import casu_pkg::*;

  logic    take_ok;
  logic    bundle_we;
  bundle_t bundle;

  casu_parse #(
    .MAX_ARGS(MAX_ARGS)
  ) u_parse (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .take_ok  (take_ok),
    .bundle_we(bundle_we),
    .bundle   (bundle)
  );

  casu_emit u_emit (
    .clk      (clk),
    .rst_n    (rst_n),
    .bundle_we(bundle_we),
    .bundle   (bundle),
    .take_ok  (take_ok),
    .out_ch   (out_ch)
  );

endmodule

### hdl/casu_parse.sv
// casu_parse: input register, parser state and the per-item result logic
// depends on casu_pkg and casu_in_if
module casu_parse #(
  parameter int unsigned MAX_ARGS = casu_pkg::MaxArgsDefault
) (
  input  logic              clk,
  input  logic              rst_n,
  casu_in_if.sink           in_ch,
  input  logic              take_ok,
  output logic              bundle_we,
  output casu_pkg::bundle_t bundle
);
  import casu_pkg::*;

  localparam logic [7:0] ArgCap = (MAX_ARGS > 255) ? 8'd255 : 8'(MAX_ARGS);

  logic        in_vld_r, in_vld_nxt;
  logic [15:0] in_cu_r;
  logic        in_eoc_r;
  logic        in_take;
  logic        fire;

  phase_t      phase_r, phase_nxt;
  logic        dq_r, dq_nxt;
  logic        esc_r, esc_nxt;
  logic [7:0]  cnt_r, cnt_nxt;
  logic        errs_r, errs_nxt;

  logic        sp;
  logic        quote;
  logic [15:0] close_q;
  err_code_t   err;
  logic [1:0]  n;
  result_t [2:0] res;

  assign in_take     = in_ch.valid && in_ch.ready;
  assign fire        = in_vld_r && take_ok;
  assign in_ch.ready = !in_vld_r || take_ok;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_take) begin
      in_vld_nxt = 1'b1;
    end else if (fire) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
    if (in_take) begin
      in_cu_r  <= in_ch.code_unit;
      in_eoc_r <= in_ch.end_of_command;
    end
  end

  assign sp      = is_space(in_cu_r);
  assign quote   = (in_cu_r == CuDquote) || (in_cu_r == CuSquote);
  assign close_q = dq_r ? CuDquote : CuSquote;

  always_comb begin
    phase_nxt = phase_r;
    dq_nxt    = dq_r;
    esc_nxt   = esc_r;
    cnt_nxt   = cnt_r;
    errs_nxt  = errs_r;
    err       = ERR_NONE;
    n         = 2'd0;
    res       = '0;

    if (errs_r) begin
      if (in_eoc_r) begin
        phase_nxt = PH_IDLE;
        dq_nxt    = 1'b0;
        esc_nxt   = 1'b0;
        cnt_nxt   = 8'd0;
        errs_nxt  = 1'b0;
      end
    end else begin
      unique case (phase_r)
        PH_IDLE: begin
          if (quote) begin
            phase_nxt = PH_QUOTED;
            dq_nxt    = (in_cu_r == CuDquote);
            esc_nxt   = 1'b0;
          end else if (!sp) begin
            phase_nxt = PH_PLAIN;
            res[n]    = mk_result(KIND_CHAR, in_cu_r, cnt_nxt, ERR_NONE);
            n         = n + 2'd1;
          end
        end
        PH_PLAIN: begin
          if (quote) begin
            err = ERR_QUOTE_IN;
          end else if (sp) begin
            res[n] = mk_result(KIND_END, 16'd0, cnt_nxt, ERR_NONE);
            n      = n + 2'd1;
            if (cnt_nxt < ArgCap) cnt_nxt = cnt_nxt + 8'd1;
            phase_nxt = PH_IDLE;
          end else begin
            res[n] = mk_result(KIND_CHAR, in_cu_r, cnt_nxt, ERR_NONE);
            n      = n + 2'd1;
          end
        end
        PH_QUOTED: begin
          if (esc_r) begin
            esc_nxt = 1'b0;
            if (in_cu_r != CuBslash && !quote) begin
              res[n] = mk_result(KIND_CHAR, CuBslash, cnt_nxt, ERR_NONE);
              n      = n + 2'd1;
            end
            res[n] = mk_result(KIND_CHAR, in_cu_r, cnt_nxt, ERR_NONE);
            n      = n + 2'd1;
          end else if (in_cu_r == CuBslash) begin
            esc_nxt = 1'b1;
          end else if (in_cu_r == close_q) begin
            res[n] = mk_result(KIND_END, 16'd0, cnt_nxt, ERR_NONE);
            n      = n + 2'd1;
            if (cnt_nxt < ArgCap) cnt_nxt = cnt_nxt + 8'd1;
            phase_nxt = PH_CLOSED;
          end else begin
            res[n] = mk_result(KIND_CHAR, in_cu_r, cnt_nxt, ERR_NONE);
            n      = n + 2'd1;
          end
        end
        PH_CLOSED: begin
          if (sp) begin
            phase_nxt = PH_IDLE;
          end else begin
            err = ERR_NO_SPACE;
          end
        end
      endcase

      if (err == ERR_NONE && in_eoc_r) begin
        if (phase_nxt == PH_QUOTED) begin
          err = ERR_UNMATCHED;
        end else begin
          if (phase_nxt == PH_PLAIN) begin
            res[n] = mk_result(KIND_END, 16'd0, cnt_nxt, ERR_NONE);
            n      = n + 2'd1;
            if (cnt_nxt < ArgCap) cnt_nxt = cnt_nxt + 8'd1;
          end
          if (cnt_nxt == 8'd0) begin
            err = ERR_NO_PROGRAM;
          end else begin
            res[n] = mk_result(KIND_OK, 16'd0, cnt_nxt, ERR_NONE);
            n      = n + 2'd1;
          end
        end
      end

      if (err != ERR_NONE) begin
        res[n] = mk_result(KIND_ERR, 16'd0, cnt_nxt, err);
        n      = n + 2'd1;
      end

      if (in_eoc_r) begin
        phase_nxt = PH_IDLE;
        dq_nxt    = 1'b0;
        esc_nxt   = 1'b0;
        cnt_nxt   = 8'd0;
        errs_nxt  = 1'b0;
      end else if (err != ERR_NONE) begin
        errs_nxt = 1'b1;
      end
    end

    if (n != 2'd0) res[n - 2'd1].last_of_run = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      dq_r    <= 1'b0;
      esc_r   <= 1'b0;
      cnt_r   <= 8'd0;
      errs_r  <= 1'b0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      dq_r    <= dq_nxt;
      esc_r   <= esc_nxt;
      cnt_r   <= cnt_nxt;
      errs_r  <= errs_nxt;
    end
  end

  assign bundle_we  = fire && (n != 2'd0);
  assign bundle.n   = n;
  assign bundle.res = res;

endmodule

### hdl/casu_emit.sv
// casu_emit: result buffer for one item and the output register
// depends on casu_pkg and casu_out_if
module casu_emit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              bundle_we,
  input  casu_pkg::bundle_t bundle,
  output logic              take_ok,
  casu_out_if.source        out_ch
);
  import casu_pkg::*;

  result_t [2:0] ent_r;
  logic [1:0]    rem_r, rem_nxt;
  logic          out_vld_r, out_vld_nxt;
  result_t       out_r;
  logic          out_load;

  assign out_load = (rem_r != 2'd0) && (!out_vld_r || out_ch.ready);
  assign take_ok  = (rem_r == 2'd0) || (out_load && rem_r == 2'd1);

  always_comb begin
    rem_nxt = rem_r;
    if (bundle_we) begin
      rem_nxt = bundle.n;
    end else if (out_load) begin
      rem_nxt = rem_r - 2'd1;
    end
    out_vld_nxt = out_vld_r;
    if (out_load) begin
      out_vld_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r     <= 2'd0;
      out_vld_r <= 1'b0;
    end else begin
      rem_r     <= rem_nxt;
      out_vld_r <= out_vld_nxt;
    end
    if (bundle_we) begin
      ent_r <= bundle.res;
    end else if (out_load) begin
      ent_r[0] <= ent_r[1];
      ent_r[1] <= ent_r[2];
    end
    if (out_load) begin
      out_r <= ent_r[0];
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.kind        = out_r.kind;
  assign out_ch.char_out    = out_r.char_out;
  assign out_ch.arg_number  = out_r.arg_number;
  assign out_ch.error_code  = out_r.error_code;
  assign out_ch.last_of_run = out_r.last_of_run;

endmodule

### hdl/casu_checker.sv
// casu_checker: port-level checks of the argument splitter's result channel
// depends on casu_pkg; bound to command_line_argument_splitter_unit
module casu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_kind,
  input logic [15:0] out_char_out,
  input logic [7:0]  out_arg_number,
  input logic [2:0]  out_error_code,
  input logic        out_last_of_run
);
  import casu_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_char_out) &&
      $stable(out_arg_number) && $stable(out_error_code) && $stable(out_last_of_run))
    else $error("result item changed while stalled");

  a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_CHAR |-> out_char_out == 16'd0)
    else $error("char_out not zero on a non-character item");

  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_kind == KIND_ERR) == (out_error_code != ERR_NONE) &&
      out_error_code <= ERR_NO_PROGRAM)
    else $error("error code does not match kind");

  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_OK || out_kind == KIND_ERR) |-> out_last_of_run)
    else $error("command end item not last of its run");

endmodule

bind command_line_argument_splitter_unit casu_checker u_casu_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_kind       (out_ch.kind),
  .out_char_out   (out_ch.char_out),
  .out_arg_number (out_ch.arg_number),
  .out_error_code (out_ch.error_code),
  .out_last_of_run(out_ch.last_of_run)
);

### tb/sv/command_line_argument_splitter_unit_tb.sv
// command_line_argument_splitter_unit_tb: self-checking bench for the argument splitter
// streams directed, random and long command lines through the item channels and
// compares every result item with an in-bench splitter; needs casu_pkg, casu_if and the rtl
module command_line_argument_splitter_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import casu_pkg::*;

  localparam int unsigned ArgCap = (MaxArgsDefault > 255) ? 255 : MaxArgsDefault;
  localparam int CycleLimit = 400000;
  localparam int SettleCycles = 8;
  localparam int RandomUnits = 170;
  localparam int LongArgs = 40;

  logic clk;
  logic rst_n;

  casu_in_if  in_ch ();
  casu_out_if out_ch ();

  command_line_argument_splitter_unit #(
    .MAX_ARGS(MaxArgsDefault)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // splitter state
  phase_t     split_phase;
  logic       quote_dbl;
  logic       escape_due;
  logic [7:0] arg_total;
  logic       cmd_failed;

  result_t    run_tokens[$];
  result_t    tokens_due[$];
  logic [15:0] line_units[$];

  result_t want;
  int      mismatch_count;
  int      units_sent;
  int      results_checked;
  int      cmds_ok;
  int      cmds_err;
  int      top_arg_number;
  int      cycle_count;
  int      stall_left;
  int      stall_len;
  logic    in_gaps;
  logic    out_stalls;

  always #2 clk = ~clk;

  function automatic logic is_blank(input logic [15:0] c);
    return (c == 16'h0020) || (c >= 16'h0009 && c <= 16'h000D) || (c == 16'h0085) ||
           (c == 16'h00A0) || (c == 16'h1680) || (c >= 16'h2000 && c <= 16'h200A) ||
           (c == 16'h2028) || (c == 16'h2029) || (c == 16'h202F) ||
           (c == 16'h205F) || (c == 16'h3000);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(6, 24);
  endfunction

  function automatic logic [15:0] pick_blank();
    case ($urandom_range(0, 9))
      0: return 16'h0020;
      1: return 16'($urandom_range(16'h0009, 16'h000D));
      2: return 16'h0085;
      3: return 16'h00A0;
      4: return 16'h1680;
      5: return 16'($urandom_range(16'h2000, 16'h200A));
      6: return ($urandom_range(0, 1) == 0) ? 16'h2028 : 16'h2029;
      7: return 16'h202F;
      8: return 16'h205F;
      default: return 16'h3000;
    endcase
  endfunction

  // any argument character that is not blank, quote or backslash
  function automatic logic [15:0] pick_plain();
    logic [15:0] c;
    c = CuBslash;
    while (is_blank(c) || c == CuDquote || c == CuSquote || c == CuBslash) begin
      if ($urandom_range(0, 3) == 0) c = 16'($urandom_range(0, 65535));
      else c = 16'($urandom_range(16'h0021, 16'h007E));
    end
    return c;
  endfunction

  function automatic logic [15:0] pick_noise();
    case ($urandom_range(0, 5))
      0: return pick_blank();
      1: return CuDquote;
      2: return CuSquote;
      3: return CuBslash;
      4: return pick_plain();
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic queue_unit(input logic [15:0] u);
    line_units = {line_units, u};
  endtask

  task automatic clear_split();
    split_phase = PH_IDLE;
    quote_dbl   = 1'b0;
    escape_due  = 1'b0;
    arg_total   = 8'd0;
    cmd_failed  = 1'b0;
  endtask

  task automatic add_token(input kind_t k, input logic [15:0] ch, input err_code_t e);
    result_t t;
    t.kind        = k;
    t.char_out    = ch;
    t.arg_number  = arg_total;
    t.error_code  = e;
    t.last_of_run = 1'b0;
    run_tokens = {run_tokens, t};
  endtask

  task automatic close_arg();
    add_token(KIND_END, 16'h0000, ERR_NONE);
    if (arg_total < ArgCap) arg_total = arg_total + 8'd1;
  endtask

  task automatic split_code_unit(input logic [15:0] cu, input logic eoc);
    logic      blank;
    logic      quote;
    err_code_t err;
    blank = is_blank(cu);
    quote = (cu == CuDquote) || (cu == CuSquote);
    err   = ERR_NONE;
    run_tokens.delete();
    if (cmd_failed) begin
      if (eoc) clear_split();
      return;
    end
    case (split_phase)
      PH_IDLE: begin
        if (quote) begin
          split_phase = PH_QUOTED;
          quote_dbl   = (cu == CuDquote);
          escape_due  = 1'b0;
        end else if (!blank) begin
          split_phase = PH_PLAIN;
          add_token(KIND_CHAR, cu, ERR_NONE);
        end
      end
      PH_PLAIN: begin
        if (quote) begin
          err = ERR_QUOTE_IN;
        end else if (blank) begin
          close_arg();
          split_phase = PH_IDLE;
        end else begin
          add_token(KIND_CHAR, cu, ERR_NONE);
        end
      end
      PH_QUOTED: begin
        if (escape_due) begin
          escape_due = 1'b0;
          if (cu != CuBslash && !quote) add_token(KIND_CHAR, CuBslash, ERR_NONE);
          add_token(KIND_CHAR, cu, ERR_NONE);
        end else if (cu == CuBslash) begin
          escape_due = 1'b1;
        end else if (cu == (quote_dbl ? CuDquote : CuSquote)) begin
          close_arg();
          split_phase = PH_CLOSED;
        end else begin
          add_token(KIND_CHAR, cu, ERR_NONE);
        end
      end
      default: begin
        if (blank) split_phase = PH_IDLE;
        else err = ERR_NO_SPACE;
      end
    endcase
    if (err == ERR_NONE && eoc) begin
      if (split_phase == PH_QUOTED) begin
        err = ERR_UNMATCHED;
      end else begin
        if (split_phase == PH_PLAIN) close_arg();
        if (arg_total == 8'd0) err = ERR_NO_PROGRAM;
        else add_token(KIND_OK, 16'h0000, ERR_NONE);
      end
    end
    if (err != ERR_NONE) begin
      add_token(KIND_ERR, 16'h0000, err);
      if (eoc) clear_split();
      else cmd_failed = 1'b1;
    end else if (eoc) begin
      clear_split();
    end
    if (run_tokens.size() > 0) run_tokens[run_tokens.size() - 1].last_of_run = 1'b1;
    foreach (run_tokens[i]) tokens_due = {tokens_due, run_tokens[i]};
  endtask

  task automatic send_unit(input logic [15:0] cu, input logic eoc);
    int gap;
    gap = in_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.code_unit      <= cu;
    in_ch.end_of_command <= eoc;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    split_code_unit(cu, eoc);
    units_sent++;
  endtask

  task automatic send_line();
    foreach (line_units[i]) send_unit(line_units[i], i == line_units.size() - 1);
  endtask

  // holds the sender until every predicted item has come out
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (tokens_due.size() != 0) @(posedge clk);
  endtask

  task automatic build_clean_line();
    int          nargs;
    int          len;
    int          style;
    logic [15:0] q;
    line_units.delete();
    if ($urandom_range(0, 3) == 0) queue_unit(pick_blank());
    nargs = $urandom_range(1, 6);
    for (int a = 0; a < nargs; a++) begin
      if (a > 0) repeat ($urandom_range(1, 2)) queue_unit(pick_blank());
      style = $urandom_range(0, 2);
      if (style == 0) begin
        len = $urandom_range(1, 5);
        repeat (len) begin
          if ($urandom_range(0, 5) == 0) queue_unit(CuBslash);
          else queue_unit(pick_plain());
        end
      end else begin
        q = (style == 2) ? CuDquote : CuSquote;
        queue_unit(q);
        len = $urandom_range(0, 5);
        repeat (len) begin
          case ($urandom_range(0, 4))
            0: begin
              queue_unit(CuBslash);
              case ($urandom_range(0, 4))
                0: queue_unit(CuBslash);
                1: queue_unit(CuDquote);
                2: queue_unit(CuSquote);
                3: queue_unit(pick_blank());
                default: queue_unit(pick_plain());
              endcase
            end
            1: queue_unit(pick_blank());
            2: queue_unit((style == 2) ? CuSquote : CuDquote);
            default: queue_unit(pick_plain());
          endcase
        end
        queue_unit(q);
      end
    end
    if ($urandom_range(0, 3) == 0) queue_unit(pick_blank());
  endtask

  task automatic build_noise_line();
    line_units.delete();
    repeat ($urandom_range(1, 8)) queue_unit(pick_noise());
  endtask

  task automatic test_directed_commands();
    in_gaps    = 1'b1;
    out_stalls = 1'b1;
    // lone top code unit: char, end, ok
    line_units = '{16'hFFFF};
    send_line();
    // null char argument, empty quotes, trailing blank
    line_units = '{16'h0000, 16'h0020, CuSquote, CuSquote, 16'h3000};
    send_line();
    drain_results();
    // blank only: no program
    line_units = '{16'h000D};
    send_line();
    // escapes inside quotes, then a char glued to the closing quote, rest ignored
    line_units = '{CuDquote, 16'h0061, CuBslash, CuDquote, CuBslash, CuBslash,
                   CuBslash, 16'h0078, CuBslash, CuSquote, CuDquote, 16'h0062, 16'h0063};
    send_line();
    // quote inside an unquoted argument
    line_units = '{16'h0070, CuSquote, 16'h0020};
    send_line();
    drain_results();
    // backslash pending when the command ends
    line_units = '{CuSquote, 16'h0071, CuBslash};
    send_line();
    drain_results();
  endtask

  task automatic test_random_commands();
    int start_units;
    start_units = units_sent;
    while (units_sent - start_units < RandomUnits) begin
      in_gaps    = ($urandom_range(0, 5) != 0);
      out_stalls = ($urandom_range(0, 5) != 0);
      if ($urandom_range(0, 4) == 0) build_noise_line();
      else build_clean_line();
      send_line();
      if ($urandom_range(0, 9) == 0) drain_results();
    end
    drain_results();
  endtask

  task automatic test_long_command();
    in_gaps    = 1'b0;
    out_stalls = 1'b1;
    line_units.delete();
    repeat (LongArgs) begin
      queue_unit(pick_plain());
      queue_unit(pick_blank());
    end
    queue_unit(CuDquote);
    queue_unit(pick_plain());
    queue_unit(CuDquote);
    send_line();
    drain_results();
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (out_stalls) begin
      stall_len = pick_gap();
      out_ch.ready <= (stall_len == 0);
      stall_left   <= (stall_len > 0) ? stall_len - 1 : 0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (tokens_due.size() == 0) begin
        $error("result item with nothing due: kind %0d char_out %h", out_ch.kind,
               out_ch.char_out);
        mismatch_count++;
      end else begin
        want = tokens_due[0];
        tokens_due.delete(0);
        if (out_ch.kind !== want.kind) begin
          $error("kind: expected %0d, actual %0d", want.kind, out_ch.kind);
          mismatch_count++;
        end
        if (out_ch.char_out !== want.char_out) begin
          $error("char_out: expected %h, actual %h", want.char_out, out_ch.char_out);
          mismatch_count++;
        end
        if (out_ch.arg_number !== want.arg_number) begin
          $error("arg_number: expected %0d, actual %0d", want.arg_number, out_ch.arg_number);
          mismatch_count++;
        end
        if (out_ch.error_code !== want.error_code) begin
          $error("error_code: expected %0d, actual %0d", want.error_code, out_ch.error_code);
          mismatch_count++;
        end
        if (out_ch.last_of_run !== want.last_of_run) begin
          $error("last_of_run: expected %0d, actual %0d", want.last_of_run,
                 out_ch.last_of_run);
          mismatch_count++;
        end
        results_checked++;
        if (want.kind == KIND_OK) cmds_ok++;
        if (want.kind == KIND_ERR) cmds_err++;
        if (int'(want.arg_number) > top_arg_number) top_arg_number = int'(want.arg_number);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d result items still due", cycle_count,
               tokens_due.size());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    clk                  = 1'b0;
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.code_unit      = 16'h0000;
    in_ch.end_of_command = 1'b0;
    out_ch.ready         = 1'b0;
    in_gaps              = 1'b0;
    out_stalls           = 1'b0;
    stall_left           = 0;
    stall_len            = 0;
    cycle_count          = 0;
    mismatch_count       = 0;
    units_sent           = 0;
    results_checked      = 0;
    cmds_ok              = 0;
    cmds_err             = 0;
    top_arg_number       = 0;
    clear_split();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_commands();
    test_random_commands();
    test_long_command();
    repeat (SettleCycles) @(posedge clk);

    $display("fed %0d code units and checked %0d result items", units_sent, results_checked);
    $display("%0d command lines split cleanly, %0d rejected, argument index reached %0d",
             cmds_ok, cmds_err, top_arg_number);
    if (mismatch_count == 0 && tokens_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### files.f
hdl/casu_pkg.sv
hdl/casu_if.sv
hdl/casu_parse.sv
hdl/casu_emit.sv
hdl/command_line_argument_splitter_unit.sv
hdl/casu_checker.sv
tb/sv/command_line_argument_splitter_unit_tb.sv
